[hw/rtl/ole_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and defaults for the ordered list engine: command codes,
// status codes and sequencer states.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int unsigned CapacityDef   = 16;
  localparam int unsigned ValueWidthDef = 32;

  typedef enum logic [2:0] {
    CMD_INSERT  = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_INS_ORD = 3'd2,
    CMD_SORT    = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_WR,
    ST_DOWN,
    ST_DOWN_WR,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_SORT_START,
    ST_SORT_LD,
    ST_SORT_CMP,
    ST_SORT_END,
    ST_READ_WAIT,
    ST_DONE
  } state_e;

endpackage

[hw/rtl/ole_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ole_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/ordered_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed values with positional insert and remove,
// ordered insert, in-place sort and read, run by a small sequencer.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the single result has been shown on done_o for one cycle, which the
// receiver must take as it comes. The entries live in one RAM with a
// registered read port and every step goes through that one port and one
// signed comparator, so time grows with the entries touched: an insert at
// position p shifts the entries from p upward, a remove at p shifts those
// above p down, an ordered insert scans for the first entry greater than
// the value and inserts there, and a sort of n entries runs n-1 passes,
// each ending one entry lower. Refused commands, unused codes and a sort of
// fewer than two entries go straight to done.
// ----------------------------------------------------------------------------
module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int unsigned CAPACITY    = CapacityDef,
  parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd_i,
  input  logic [4:0]  position_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [4:0]  length_o,
  output logic [31:0] read_value_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 5) ? CW : 5;
  localparam int unsigned VW = VALUE_WIDTH;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [VW-1:0] val_q, val_d;
  logic [VW-1:0] hold_q, hold_d;
  logic [VW-1:0] rd_q, rd_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] ram_rdata;

  logic [PW-1:0] posx, cntx;
  logic          pos_gt_cnt, pos_ge_cnt, full;
  logic [CW-1:0] idx_m1, idx_p1, cnt_m1;
  logic [VW-1:0] cmp_a, cmp_b;
  logic          lt;
  logic [63:0]   val64;
  logic [63:0]   rd64;

  assign posx       = PW'(position_i);
  assign cntx       = PW'(count_q);
  assign pos_gt_cnt = posx > cntx;
  assign pos_ge_cnt = posx >= cntx;
  assign full       = count_q == CW'(CAPACITY);
  assign idx_m1     = idx_q - CW'(1);
  assign idx_p1     = idx_q + CW'(1);
  assign cnt_m1     = count_q - CW'(1);
  assign val64      = {{32{value_i[31]}}, value_i};
  assign rd64       = 64'($signed(rd_q));

  // shared signed comparator
  always_comb begin
    if (state_q == ST_SCAN_CMP) begin
      cmp_a = val_q;
      cmp_b = ram_rdata;
    end else begin
      cmp_a = ram_rdata;
      cmp_b = hold_q;
    end
  end
  assign lt = $signed(cmp_a) < $signed(cmp_b);

  ole_ram #(
    .Width(VW),
    .Depth(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (cmd_e'(cmd_i))
            CMD_INSERT:  state_d = (pos_gt_cnt || full) ? ST_DONE : ST_UP;
            CMD_REMOVE:  state_d = pos_ge_cnt ? ST_DONE : ST_DOWN;
            CMD_INS_ORD: state_d = full ? ST_DONE : ST_SCAN;
            CMD_SORT:    state_d = (count_q < CW'(2)) ? ST_DONE : ST_SORT_START;
            CMD_READ:    state_d = pos_ge_cnt ? ST_DONE : ST_READ_WAIT;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_UP:         state_d = (idx_q == pos_q) ? ST_DONE : ST_UP_WR;
      ST_UP_WR:      state_d = ST_UP;
      ST_DOWN:       state_d = (idx_p1 >= count_q) ? ST_DONE : ST_DOWN_WR;
      ST_DOWN_WR:    state_d = ST_DOWN;
      ST_SCAN:       state_d = (idx_q == count_q) ? ST_UP : ST_SCAN_CMP;
      ST_SCAN_CMP:   state_d = lt ? ST_UP : ST_SCAN;
      ST_SORT_START: state_d = ST_SORT_LD;
      ST_SORT_LD:    state_d = ST_SORT_CMP;
      ST_SORT_CMP:   state_d = (idx_q == pos_q) ? ST_SORT_END : ST_SORT_CMP;
      ST_SORT_END:   state_d = (pos_q == CW'(1)) ? ST_DONE : ST_SORT_START;
      ST_READ_WAIT:  state_d = ST_DONE;
      ST_DONE:       state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    status_d  = status_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    val_d     = val_q;
    hold_d    = hold_q;
    rd_d      = rd_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          status_d = STAT_OK;
          rd_d     = '0;
          val_d    = val64[VW-1:0];
          case (cmd_e'(cmd_i))
            CMD_INSERT: begin
              if (pos_gt_cnt) begin
                status_d = STAT_BAD_POS;
              end else if (full) begin
                status_d = STAT_FULL;
              end
              idx_d = count_q;
              pos_d = posx[CW-1:0];
            end
            CMD_REMOVE: begin
              if (pos_ge_cnt) begin
                status_d = STAT_BAD_POS;
              end
              idx_d = posx[CW-1:0];
            end
            CMD_INS_ORD: begin
              if (full) begin
                status_d = STAT_FULL;
              end
              idx_d = '0;
            end
            CMD_SORT: begin
              pos_d = cnt_m1;
            end
            CMD_READ: begin
              if (pos_ge_cnt) begin
                status_d = STAT_BAD_POS;
              end
              ram_raddr = posx[AW-1:0];
            end
            default: begin
            end
          endcase
        end
      end
      ST_UP: begin
        if (idx_q == pos_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_q[AW-1:0];
          ram_wdata = val_q;
          count_d   = count_q + CW'(1);
        end else begin
          ram_raddr = idx_m1[AW-1:0];
        end
      end
      ST_UP_WR: begin
        ram_we = 1'b1;
        idx_d  = idx_m1;
      end
      ST_DOWN: begin
        if (idx_p1 >= count_q) begin
          count_d = cnt_m1;
        end else begin
          ram_raddr = idx_p1[AW-1:0];
        end
      end
      ST_DOWN_WR: begin
        ram_we = 1'b1;
        idx_d  = idx_p1;
      end
      ST_SCAN: begin
        if (idx_q == count_q) begin
          pos_d = idx_q;
        end else begin
          ram_raddr = idx_q[AW-1:0];
        end
      end
      ST_SCAN_CMP: begin
        if (lt) begin
          pos_d = idx_q;
          idx_d = count_q;
        end else begin
          idx_d = idx_p1;
        end
      end
      ST_SORT_START: begin
        idx_d = CW'(1);
      end
      ST_SORT_LD: begin
        hold_d    = ram_rdata;
        ram_raddr = idx_q[AW-1:0];
      end
      ST_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_m1[AW-1:0];
        if (lt) begin
          ram_wdata = ram_rdata;
        end else begin
          ram_wdata = hold_q;
          hold_d    = ram_rdata;
        end
        if (idx_q != pos_q) begin
          idx_d     = idx_p1;
          ram_raddr = idx_p1[AW-1:0];
        end
      end
      ST_SORT_END: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = hold_q;
        pos_d     = pos_q - CW'(1);
      end
      ST_READ_WAIT: begin
        rd_d = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      status_q <= STAT_OK;
      count_q  <= '0;
      idx_q    <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    hold_q <= hold_d;
    rd_q   <= rd_d;
  end

  assign busy         = state_q != ST_IDLE;
  assign done_o       = state_q == ST_DONE;
  assign status_o     = status_q;
  assign length_o     = 5'(count_q);
  assign read_value_o = rd64[31:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("transaction accepted without going busy");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (busy && !done_o))
    else $error("ram write outside command execution");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == STAT_FULL) |-> full)
    else $error("full status with free entries");

endmodule
